/* src/bts_pkg.sv */
// ----------------------------------------------------------------------------
// bts_pkg: shared constants and types of the booster torque shaper
// Field widths, register indexes, fixed-point constants and the request and
// response records of the serial multiply and divide units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bts_pkg;

    // field widths
    localparam int CurW     = 12;
    localparam int AngW     = 13;
    localparam int ScaleW   = 16;
    localparam int AlphaW   = 16;
    localparam int ErpmW    = 17;
    localparam int ErrW     = 16;
    localparam int OutW     = 18;
    localparam int AvgW     = 32;

    // configuration port
    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] REG_ACCEL_CURRENT = 4'd0;
    localparam logic [CfgIdxW-1:0] REG_ACCEL_ANGLE   = 4'd1;
    localparam logic [CfgIdxW-1:0] REG_ACCEL_RAMP    = 4'd2;
    localparam logic [CfgIdxW-1:0] REG_BRAKE_CURRENT = 4'd3;
    localparam logic [CfgIdxW-1:0] REG_BRAKE_ANGLE   = 4'd4;
    localparam logic [CfgIdxW-1:0] REG_BRAKE_RAMP    = 4'd5;
    localparam logic [CfgIdxW-1:0] REG_TORQUE_SCALE  = 4'd6;
    localparam logic [CfgIdxW-1:0] REG_ALPHA         = 4'd7;

    // serial units: 17 steps each
    localparam int MulW     = 17;
    localparam int ProdW    = 2 * MulW;
    localparam int DivW     = 17;
    localparam int DivRemW  = 18;

    // fixed-point constants
    localparam int ScaleFrac = 12;
    localparam int StiffFrac = 16;
    localparam int FracBits  = 14;
    localparam logic [ErpmW-1:0] ErpmMin  = 17'd3000;
    localparam logic [ErpmW-1:0] ErpmSpan = 17'd10000;
    localparam logic [MulW-1:0]  StiffOne = 17'h10000;

    typedef struct packed {
        logic            start;
        logic [MulW-1:0] a;
        logic [MulW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic             done;
        logic [ProdW-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic               start;
        logic [DivRemW-1:0] rem_init;
        logic [DivW-1:0]    num;
        logic [DivRemW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [DivW-1:0] quot;
    } div_rsp_t;

endpackage

/* src/bts_mul.sv */
// ----------------------------------------------------------------------------
// bts_mul: bit-serial unsigned multiplier
// Shift-and-add, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bts_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  bts_pkg::mul_req_t req,
    output bts_pkg::mul_rsp_t rsp
);
    import bts_pkg::*;

    localparam int CntW = $clog2(MulW);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [MulW-1:0] a_reg, a_next;
    logic [MulW:0]   hi_reg, hi_next;
    logic [MulW-1:0] lo_reg, lo_next;
    logic [MulW:0]   sum;

    always_comb begin
        sum       = hi_reg + (lo_reg[0] ? {1'b0, a_reg} : '0);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = req.a;
            hi_next   = '0;
            lo_next   = req.b;
        end else if (busy_reg) begin
            // partial sum shifts down into the spent multiplier bits
            hi_next  = {1'b0, sum[MulW:1]};
            lo_next  = {sum[0], lo_reg[MulW-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(MulW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = {hi_reg[MulW-1:0], lo_reg};

endmodule

/* src/bts_div.sv */
// ----------------------------------------------------------------------------
// bts_div: bit-serial restoring divider
// Starts from a partial remainder below the divisor and shifts in 17 further
// dividend bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bts_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  bts_pkg::div_req_t req,
    output bts_pkg::div_rsp_t rsp
);
    import bts_pkg::*;

    localparam int CntW = $clog2(DivW);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CntW-1:0]    cnt_reg, cnt_next;
    logic [DivRemW-1:0] rem_reg, rem_next;
    logic [DivRemW-1:0] den_reg, den_next;
    logic [DivW-1:0]    num_reg, num_next;
    logic [DivW-1:0]    quot_reg, quot_next;
    logic [DivRemW:0]   shifted;
    logic [DivRemW:0]   trial;
    logic               fits;

    always_comb begin
        shifted   = {rem_reg, num_reg[DivW-1]};
        trial     = shifted - {1'b0, den_reg};
        fits      = shifted >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.rem_init;
            den_next  = req.den;
            num_next  = req.num;
        end else if (busy_reg) begin
            rem_next  = fits ? trial[DivRemW-1:0] : shifted[DivRemW-1:0];
            num_next  = {num_reg[DivW-2:0], 1'b0};
            quot_next = {quot_reg[DivW-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(DivW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

/* src/booster_torque_shaper.sv */
// ----------------------------------------------------------------------------
// booster_torque_shaper: speed-dependent booster torque with smoothing
// Usage:
//   Configuration registers are written through cfg_wr_en / cfg_index /
//   cfg_wdata while the block is idle; unknown indexes are ignored.
//   One input transfer (braking flag, speed, angle error) on s_* gives one
//   result transfer (smoothed signed torque) on m_*.
//   An item runs through one bit-serial multiplier and one bit-serial divider,
//   five passes of 17 steps each (base torque, stiffness, brake scaling or
//   start angle division, ramp product, ramp division), then 16 steps of the
//   averaging multiply-accumulate, one alpha bit per step. One item is in
//   flight at a time.
//   s_ready is high while the sequencer is idle, also while a finished result
//   still waits in the output register. If the receiver stalls, the next item
//   runs to completion and then waits until the output register is free.
//   Reset (synchronous, active low) restores register defaults and clears the
//   torque average and all handshake state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module booster_torque_shaper (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bts_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [bts_pkg::CfgDataW-1:0]      cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_is_braking,
    input  logic [bts_pkg::ErpmW-1:0]         s_speed_erpm,
    input  logic signed [bts_pkg::ErrW-1:0]   s_angle_error,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [bts_pkg::OutW-1:0]   m_boost_torque
);
    import bts_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_MUL_T   = 4'd1;
    localparam logic [3:0] ST_DIV_S   = 4'd2;
    localparam logic [3:0] ST_ADJ_MUL = 4'd3;
    localparam logic [3:0] ST_ADJ_DIV = 4'd4;
    localparam logic [3:0] ST_CMP     = 4'd5;
    localparam logic [3:0] ST_MUL_D   = 4'd6;
    localparam logic [3:0] ST_DIV_R   = 4'd7;
    localparam logic [3:0] ST_DIFF    = 4'd8;
    localparam logic [3:0] ST_AVG     = 4'd9;
    localparam logic [3:0] ST_UPD     = 4'd10;
    localparam logic [3:0] ST_OUT     = 4'd11;

    localparam int AvgCntW = $clog2(AlphaW);
    localparam int DiffW   = AvgW + 1;
    localparam int AccW    = AvgW + 2;
    localparam int SumW    = AvgW + 3;
    localparam int YW      = AvgW + 1 - FracBits;

    // configuration registers
    logic [CurW-1:0]   accel_current_reg, brake_current_reg;
    logic [AngW-1:0]   accel_angle_reg, accel_ramp_reg;
    logic [AngW-1:0]   brake_angle_reg, brake_ramp_reg;
    logic [ScaleW-1:0] torque_scale_reg;
    logic [AlphaW-1:0] smoothing_alpha_reg;

    // control
    logic [3:0]         state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [AvgW-1:0] avg_reg, avg_next;
    mul_req_t           mul_req_reg, mul_req_next;
    div_req_t           div_req_reg, div_req_next;
    mul_rsp_t           mul_rsp;
    div_rsp_t           div_rsp;

    // item payload
    logic               brk_reg, brk_next;
    logic [ErpmW-1:0]   erpm_reg, erpm_next;
    logic               neg_reg, neg_next;
    logic [MulW-1:0]    magerr_reg, magerr_next;
    logic [AngW-1:0]    ang_reg, ang_next;
    logic [AngW-1:0]    ramp_reg, ramp_next;
    logic [MulW-1:0]    t_reg, t_next;
    logic               zero_reg, zero_next;
    logic               full_reg, full_next;
    logic [MulW-1:0]    mag_reg, mag_next;
    logic signed [DiffW-1:0] diff_reg, diff_next;
    logic signed [AccW-1:0]  acc_reg, acc_next;
    logic [AlphaW-1:0]  alpha_reg, alpha_next;
    logic [AvgCntW-1:0] cnt_reg, cnt_next;
    logic signed [OutW-1:0] out_reg, out_next;

    // combinational helpers
    logic [MulW-1:0]    err_ext;
    logic [MulW-1:0]    magerr_in;
    logic               erpm_over;
    logic [ErpmW-1:0]   erpm_ex;
    logic               ex_sat;
    logic [MulW-1:0]    stiff;
    logic [MulW-1:0]    d_val;
    logic signed [AvgW-1:0]  x_pos;
    logic signed [DiffW-1:0] x_ext;
    logic signed [DiffW-1:0] avg_ext;
    logic signed [AccW-1:0]  addend;
    logic signed [AccW-1:0]  acc_sum;
    logic signed [SumW-1:0]  new_avg;
    logic signed [DiffW-1:0] y_sum;
    logic signed [YW-1:0]    y_val;
    logic signed [OutW-1:0]  y_sat;

    bts_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req_reg),
        .rsp     (mul_rsp)
    );

    bts_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req_reg),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_current_reg   <= '0;
            accel_angle_reg     <= '0;
            accel_ramp_reg      <= AngW'(256);
            brake_current_reg   <= '0;
            brake_angle_reg     <= '0;
            brake_ramp_reg      <= AngW'(256);
            torque_scale_reg    <= ScaleW'(4096);
            smoothing_alpha_reg <= '1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ACCEL_CURRENT: accel_current_reg   <= cfg_wdata[CurW-1:0];
                REG_ACCEL_ANGLE:   accel_angle_reg     <= cfg_wdata[AngW-1:0];
                REG_ACCEL_RAMP:    accel_ramp_reg      <= cfg_wdata[AngW-1:0];
                REG_BRAKE_CURRENT: brake_current_reg   <= cfg_wdata[CurW-1:0];
                REG_BRAKE_ANGLE:   brake_angle_reg     <= cfg_wdata[AngW-1:0];
                REG_BRAKE_RAMP:    brake_ramp_reg      <= cfg_wdata[AngW-1:0];
                REG_TORQUE_SCALE:  torque_scale_reg    <= cfg_wdata[ScaleW-1:0];
                REG_ALPHA:         smoothing_alpha_reg <= cfg_wdata[AlphaW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        // magnitude of the angle error; the most negative value gives 32768
        err_ext   = {s_angle_error[ErrW-1], s_angle_error};
        magerr_in = s_angle_error[ErrW-1] ? (~err_ext + 1'b1) : err_ext;

        erpm_over = erpm_reg > ErpmMin;
        erpm_ex   = erpm_reg - ErpmMin;
        ex_sat    = erpm_ex >= ErpmSpan;
        // divider ran one step long, so drop the last quotient bit
        if (!erpm_over) begin
            stiff = '0;
        end else if (ex_sat) begin
            stiff = StiffOne;
        end else begin
            stiff = {1'b0, div_rsp.quot[DivW-1:1]};
        end

        d_val   = magerr_reg - {{(MulW-AngW){1'b0}}, ang_reg};
        x_pos   = {1'b0, mag_reg[AvgW-FracBits-2:0], {FracBits{1'b0}}};
        x_ext   = neg_reg ? -{x_pos[AvgW-1], x_pos} : {x_pos[AvgW-1], x_pos};
        avg_ext = {avg_reg[AvgW-1], avg_reg};
        addend  = alpha_reg[0] ? {diff_reg[DiffW-1], diff_reg} : '0;
        acc_sum = acc_reg + addend;
        new_avg = {{3{avg_reg[AvgW-1]}}, avg_reg} + {acc_reg[AccW-1], acc_reg};
        y_sum   = avg_ext + DiffW'(1 << (FracBits - 1));
        y_val   = y_sum[DiffW-1:FracBits];
        if (y_val[YW-1] != y_val[OutW-1]) begin
            y_sat = y_val[YW-1] ? {1'b1, {(OutW-1){1'b0}}} : {1'b0, {(OutW-1){1'b1}}};
        end else begin
            y_sat = y_val[OutW-1:0];
        end

        state_next         = state_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        avg_next           = avg_reg;
        mul_req_next       = mul_req_reg;
        mul_req_next.start = 1'b0;
        div_req_next       = div_req_reg;
        div_req_next.start = 1'b0;
        brk_next           = brk_reg;
        erpm_next          = erpm_reg;
        neg_next           = neg_reg;
        magerr_next        = magerr_reg;
        ang_next           = ang_reg;
        ramp_next          = ramp_reg;
        t_next             = t_reg;
        zero_next          = zero_reg;
        full_next          = full_reg;
        mag_next           = mag_reg;
        diff_next          = diff_reg;
        acc_next           = acc_reg;
        alpha_next         = alpha_reg;
        cnt_next           = cnt_reg;
        out_next           = out_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    brk_next           = s_is_braking;
                    erpm_next          = s_speed_erpm;
                    neg_next           = s_angle_error[ErrW-1];
                    magerr_next        = magerr_in;
                    ang_next           = s_is_braking ? brake_angle_reg : accel_angle_reg;
                    ramp_next          = s_is_braking ? brake_ramp_reg : accel_ramp_reg;
                    mul_req_next.start = 1'b1;
                    mul_req_next.a     = MulW'(s_is_braking ? brake_current_reg
                                                            : accel_current_reg);
                    mul_req_next.b     = MulW'(torque_scale_reg);
                    state_next         = ST_MUL_T;
                end
            end
            ST_MUL_T: begin
                if (mul_rsp.done) begin
                    t_next                = mul_rsp.prod[ScaleFrac +: MulW];
                    div_req_next.start    = 1'b1;
                    div_req_next.rem_init = ex_sat ? '0 : DivRemW'(erpm_ex);
                    div_req_next.num      = '0;
                    div_req_next.den      = DivRemW'(ErpmSpan);
                    state_next            = ST_DIV_S;
                end
            end
            ST_DIV_S: begin
                if (div_rsp.done) begin
                    if (brk_reg) begin
                        mul_req_next.start = 1'b1;
                        mul_req_next.a     = t_reg;
                        mul_req_next.b     = stiff;
                        state_next         = ST_ADJ_MUL;
                    end else begin
                        div_req_next.start    = 1'b1;
                        div_req_next.rem_init = DivRemW'(ang_reg);
                        div_req_next.num      = '0;
                        div_req_next.den      = {1'b0, stiff} + {1'b0, StiffOne};
                        state_next            = ST_ADJ_DIV;
                    end
                end
            end
            ST_ADJ_MUL: begin
                if (mul_rsp.done) begin
                    t_next     = t_reg + mul_rsp.prod[StiffFrac +: MulW];
                    state_next = ST_CMP;
                end
            end
            ST_ADJ_DIV: begin
                if (div_rsp.done) begin
                    ang_next   = div_rsp.quot[AngW:1];
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                zero_next          = magerr_reg <= MulW'(ang_reg);
                full_next          = d_val >= MulW'(ramp_reg);
                mul_req_next.start = 1'b1;
                mul_req_next.a     = t_reg;
                mul_req_next.b     = d_val;
                state_next         = ST_MUL_D;
            end
            ST_MUL_D: begin
                if (mul_rsp.done) begin
                    // where d is below the ramp, the product is below t * ramp, so its top part is below the ramp
                    div_req_next.start    = 1'b1;
                    div_req_next.rem_init = DivRemW'(mul_rsp.prod[DivW +: AngW]);
                    div_req_next.num      = mul_rsp.prod[DivW-1:0];
                    div_req_next.den      = DivRemW'(ramp_reg);
                    state_next            = ST_DIV_R;
                end
            end
            ST_DIV_R: begin
                if (div_rsp.done) begin
                    if (zero_reg) begin
                        mag_next = '0;
                    end else if (full_reg) begin
                        mag_next = t_reg;
                    end else begin
                        mag_next = div_rsp.quot;
                    end
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                diff_next  = x_ext - avg_ext;
                acc_next   = '0;
                alpha_next = smoothing_alpha_reg;
                cnt_next   = '0;
                state_next = ST_AVG;
            end
            ST_AVG: begin
                // LSB-first multiply, arithmetic shift keeps the floor exact
                acc_next   = {acc_sum[AccW-1], acc_sum[AccW-1:1]};
                alpha_next = {1'b0, alpha_reg[AlphaW-1:1]};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == AvgCntW'(AlphaW - 1)) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                if (new_avg > $signed({{(SumW-AvgW+1){1'b0}}, {(AvgW-1){1'b1}}})) begin
                    avg_next = {1'b0, {(AvgW-1){1'b1}}};
                end else if (new_avg < $signed({{(SumW-AvgW+1){1'b1}},
                                                {(AvgW-1){1'b0}}})) begin
                    avg_next = {1'b1, {(AvgW-1){1'b0}}};
                end else begin
                    avg_next = new_avg[AvgW-1:0];
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = y_sat;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            avg_reg     <= '0;
            mul_req_reg <= '0;
            div_req_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            avg_reg     <= avg_next;
            mul_req_reg <= mul_req_next;
            div_req_reg <= div_req_next;
        end
    end

    always_ff @(posedge aclk) begin
        brk_reg    <= brk_next;
        erpm_reg   <= erpm_next;
        neg_reg    <= neg_next;
        magerr_reg <= magerr_next;
        ang_reg    <= ang_next;
        ramp_reg   <= ramp_next;
        t_reg      <= t_next;
        zero_reg   <= zero_next;
        full_reg   <= full_next;
        mag_reg    <= mag_next;
        diff_reg   <= diff_next;
        acc_reg    <= acc_next;
        alpha_reg  <= alpha_next;
        cnt_reg    <= cnt_next;
        out_reg    <= out_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_boost_torque = out_reg;

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_MUL_T && mul_req_reg.start))
        else $error("transfer in did not start the base torque product");

    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> (state_reg == ST_MUL_T || state_reg == ST_ADJ_MUL
                          || state_reg == ST_MUL_D))
        else $error("multiplier finished while sequencer not waiting on it");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV_S || state_reg == ST_ADJ_DIV
                          || state_reg == ST_DIV_R))
        else $error("divider finished while sequencer not waiting on it");

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result valid raised outside the output step");
`endif

endmodule

/* test/booster_torque_shaper_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// booster_torque_shaper_test: self-checking bench for the booster torque shaper
// A short table of hand-picked ticks (reset values, register extremes, zero
// ramp, zero alpha, speed thresholds, most negative error) is followed by
// blocks of random ticks under random register settings. Each accepted tick
// is run through a local fixed-point model of the shaper. The model's torque,
// or a table row's fixed torque, is queued and compared with each result
// transfer in order. Sender gaps and receiver stalls vary from block to block.
// ----------------------------------------------------------------------------

module booster_torque_shaper_test;
    import bts_pkg::*;

    localparam int NumBlocks     = 16;
    localparam int ItemsPerBlock = 80;
    localparam int CycleLimit    = 1_000_000;
    localparam int HoldCycles    = 900;
    localparam int TailCycles    = 150;
    localparam int GapPct[4]     = '{0, 49, 0, 29};
    localparam int StallPct[4]   = '{0, 0, 49, 29};

    localparam longint AvgTop = (longint'(1) <<< (AvgW - 1)) - 1;
    localparam longint AvgBot = -(longint'(1) <<< (AvgW - 1));
    localparam longint OutTop = (longint'(1) <<< (OutW - 1)) - 1;
    localparam longint OutBot = -(longint'(1) <<< (OutW - 1));

    typedef struct packed {
        logic [CurW-1:0]   acc_cur;
        logic [AngW-1:0]   acc_ang;
        logic [AngW-1:0]   acc_ramp;
        logic [CurW-1:0]   brk_cur;
        logic [AngW-1:0]   brk_ang;
        logic [AngW-1:0]   brk_ramp;
        logic [ScaleW-1:0] tq_scale;
        logic [AlphaW-1:0] alpha;
    } shaper_regs_t;

    typedef struct packed {
        logic [1:0]               setting;
        logic                     brk;
        logic [ErpmW-1:0]         erpm;
        logic signed [ErrW-1:0]   err;
        logic                     fixed_due;
        logic signed [OutW-1:0]   torque;
    } tick_row_t;

    localparam int NumRows = 24;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]         cfg_index = '0;
    logic [CfgDataW-1:0]        cfg_wdata = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_is_braking = 1'b0;
    logic [ErpmW-1:0]           s_speed_erpm = '0;
    logic signed [ErrW-1:0]     s_angle_error = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [OutW-1:0]     m_boost_torque;

    shaper_regs_t               regs;
    longint                     torque_avg;
    logic signed [OutW-1:0]     pending_torque[$];
    tick_row_t                  plan [NumRows];
    int                         gap_pct = 0;
    int                         stall_pct = 0;
    int                         ready_hold = 0;
    int                         mismatches = 0;
    int                         cycle_count = 0;

    booster_torque_shaper dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_is_braking   (s_is_braking),
        .s_speed_erpm   (s_speed_erpm),
        .s_angle_error  (s_angle_error),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_boost_torque (m_boost_torque)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // torque for one tick; advances the running average
    function automatic logic signed [OutW-1:0] next_boost_torque(
        input logic brk, input logic [ErpmW-1:0] erpm, input logic [ErrW-1:0] err);
        longint unsigned tq, ang, ramp, mag, stiff, err_mag, d;
        longint x, avg, y;
        err_mag = err[ErrW-1] ? (64'd1 << ErrW) - 64'(err) : 64'(err);
        if (brk) begin
            tq   = (64'(regs.brk_cur) * regs.tq_scale) >> ScaleFrac;
            ang  = regs.brk_ang;
            ramp = regs.brk_ramp;
        end else begin
            tq   = (64'(regs.acc_cur) * regs.tq_scale) >> ScaleFrac;
            ang  = regs.acc_ang;
            ramp = regs.acc_ramp;
        end
        if (erpm > ErpmMin) begin
            stiff = ((64'(erpm) - ErpmMin) << StiffFrac) / ErpmSpan;
            if (stiff > StiffOne)
                stiff = StiffOne;
            if (brk)
                tq += (tq * stiff) >> StiffFrac;
            else
                ang = (ang << StiffFrac) / (64'(StiffOne) + stiff);
        end
        if (err_mag > ang) begin
            d   = err_mag - ang;
            mag = (d < ramp) ? (tq * d) / ramp : tq;
        end else begin
            mag = 0;
        end
        x = longint'(mag) <<< FracBits;
        if (err[ErrW-1])
            x = -x;
        avg = torque_avg + (((x - torque_avg) * longint'(regs.alpha)) >>> AlphaW);
        if (avg > AvgTop)
            avg = AvgTop;
        if (avg < AvgBot)
            avg = AvgBot;
        torque_avg = avg;
        y = (avg + (longint'(1) <<< (FracBits - 1))) >>> FracBits;
        if (y > OutTop)
            y = OutTop;
        if (y < OutBot)
            y = OutBot;
        return y[OutW-1:0];
    endfunction

    // mostly typical values, with both extremes and raw 16-bit data mixed in
    function automatic logic [CfgDataW-1:0] pick_reg(input int top, input int typical);
        case ($urandom_range(7))
            0: return '0;
            1: return CfgDataW'(top);
            2: return CfgDataW'($urandom);
            default: return CfgDataW'($urandom_range(0, typical));
        endcase
    endfunction

    // all tasks below start and end at a falling edge
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        case (idx)
            REG_ACCEL_CURRENT: regs.acc_cur  = data[CurW-1:0];
            REG_ACCEL_ANGLE:   regs.acc_ang  = data[AngW-1:0];
            REG_ACCEL_RAMP:    regs.acc_ramp = data[AngW-1:0];
            REG_BRAKE_CURRENT: regs.brk_cur  = data[CurW-1:0];
            REG_BRAKE_ANGLE:   regs.brk_ang  = data[AngW-1:0];
            REG_BRAKE_RAMP:    regs.brk_ramp = data[AngW-1:0];
            REG_TORQUE_SCALE:  regs.tq_scale = data[ScaleW-1:0];
            REG_ALPHA:         regs.alpha    = data[AlphaW-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic offer_tick(input logic brk, input logic [ErpmW-1:0] erpm,
                              input logic [ErrW-1:0] err, input logic fixed_due,
                              input logic signed [OutW-1:0] torque);
        logic signed [OutW-1:0] due;
        while ($urandom_range(99) < gap_pct)
            @(negedge aclk);
        s_valid       = 1'b1;
        s_is_braking  = brk;
        s_speed_erpm  = erpm;
        s_angle_error = err;
        do @(posedge aclk); while (!s_ready);
        due = next_boost_torque(brk, erpm, err);
        pending_torque.push_back(fixed_due ? torque : due);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_torque.size() != 0)
            @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready = 1'b0;
            ready_hold--;
        end else begin
            m_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : check_torque
        logic signed [OutW-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_torque.size() == 0) begin
                $display("%0t: boost_torque expected none, got %0d", $time, m_boost_torque);
                mismatches++;
            end else begin
                want = pending_torque.pop_front();
                if (m_boost_torque !== want) begin
                    $display("%0t: boost_torque expected %0d, got %0d",
                             $time, want, m_boost_torque);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("booster_torque_shaper_test NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        int                  setting_now;
        int                  m;
        int                  base;
        int                  span;
        logic                brk;
        logic [ErpmW-1:0]    erpm;
        logic [ErrW-1:0]     err;
        logic [CfgIdxW-1:0]  spare;

        // register defaults after reset: ramps 1 degree, scale 1.0, alpha ~1.0
        regs          = '0;
        regs.acc_ramp = 13'd256;
        regs.brk_ramp = 13'd256;
        regs.tq_scale = 16'd4096;
        regs.alpha    = 16'hFFFF;
        torque_avg    = 0;

        plan = '{
            // defaults: both currents zero, so no torque at all
            '{2'd0, 1'b0, 17'd0,      16'sd0,      1'b1, 18'sd0},
            '{2'd0, 1'b1, 17'd131071, 16'sd32767,  1'b1, 18'sd0},
            '{2'd0, 1'b0, 17'd3001,   -16'sd32768, 1'b1, 18'sd0},
            '{2'd0, 1'b1, 17'd3000,   -16'sd23040, 1'b1, 18'sd0},
            // full currents and scale, zero angles and ramps
            '{2'd1, 1'b1, 17'd131071, 16'sd23040,  1'b0, 18'sd0},
            '{2'd1, 1'b1, 17'd131071, -16'sd32768, 1'b0, 18'sd0},
            '{2'd1, 1'b0, 17'd0,      16'sd1,      1'b0, 18'sd0},
            '{2'd1, 1'b0, 17'd3000,   -16'sd1,     1'b0, 18'sd0},
            '{2'd1, 1'b1, 17'd3001,   16'sd100,    1'b0, 18'sd0},
            '{2'd1, 1'b1, 17'd13000,  16'sd0,      1'b0, 18'sd0},
            '{2'd1, 1'b0, 17'd131071, 16'sd23040,  1'b0, 18'sd0},
            '{2'd1, 1'b1, 17'd0,      -16'sd23040, 1'b0, 18'sd0},
            // zero alpha: the average must hold
            '{2'd2, 1'b0, 17'd5000,   16'sd23040,  1'b0, 18'sd0},
            '{2'd2, 1'b1, 17'd0,      -16'sd32768, 1'b0, 18'sd0},
            '{2'd2, 1'b0, 17'd131071, 16'sd7680,   1'b0, 18'sd0},
            // start angle and ramp edges
            '{2'd3, 1'b0, 17'd0,      16'sd2000,   1'b0, 18'sd0},
            '{2'd3, 1'b0, 17'd0,      16'sd2001,   1'b0, 18'sd0},
            '{2'd3, 1'b0, 17'd0,      16'sd2499,   1'b0, 18'sd0},
            '{2'd3, 1'b0, 17'd0,      -16'sd2500,  1'b0, 18'sd0},
            '{2'd3, 1'b0, 17'd8000,   16'sd2000,   1'b0, 18'sd0},
            '{2'd3, 1'b1, 17'd0,      16'sd1000,   1'b0, 18'sd0},
            '{2'd3, 1'b1, 17'd0,      16'sd1001,   1'b0, 18'sd0},
            '{2'd3, 1'b1, 17'd9000,   -16'sd9191,  1'b0, 18'sd0},
            '{2'd3, 1'b1, 17'd131071, 16'sd32767,  1'b0, 18'sd0}
        };

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        setting_now = 0;
        foreach (plan[i]) begin
            if (plan[i].setting != setting_now) begin
                wait_drained();
                setting_now = plan[i].setting;
                case (setting_now)
                    1: begin
                        write_reg(REG_ACCEL_CURRENT, 16'd4095);
                        write_reg(REG_ACCEL_ANGLE,   16'd0);
                        write_reg(REG_ACCEL_RAMP,    16'd0);
                        write_reg(REG_BRAKE_CURRENT, 16'd4095);
                        write_reg(REG_BRAKE_ANGLE,   16'd0);
                        write_reg(REG_BRAKE_RAMP,    16'd0);
                        write_reg(REG_TORQUE_SCALE,  16'hFFFF);
                        write_reg(REG_ALPHA,         16'hFFFF);
                        // unknown index, must leave every register alone
                        write_reg(REG_ALPHA + 1'b1,  16'hFFFF);
                    end
                    2: begin
                        write_reg(REG_ACCEL_CURRENT, 16'd2048);
                        write_reg(REG_ACCEL_ANGLE,   16'd7680);
                        write_reg(REG_ACCEL_RAMP,    16'd7680);
                        write_reg(REG_BRAKE_CURRENT, 16'd1000);
                        write_reg(REG_BRAKE_ANGLE,   16'd7680);
                        write_reg(REG_BRAKE_RAMP,    16'd7680);
                        write_reg(REG_TORQUE_SCALE,  16'd4096);
                        write_reg(REG_ALPHA,         16'd0);
                    end
                    default: begin
                        // upper data bits beyond each field are dropped
                        write_reg(REG_ACCEL_CURRENT, 16'hFFFF);
                        write_reg(REG_ACCEL_ANGLE,   16'd2000);
                        write_reg(REG_ACCEL_RAMP,    16'd500);
                        write_reg(REG_BRAKE_CURRENT, 16'd3000);
                        write_reg(REG_BRAKE_ANGLE,   16'd1000);
                        write_reg(REG_BRAKE_RAMP,    16'hFFFF);
                        write_reg(REG_ALPHA,         16'h8000);
                    end
                endcase
            end
            offer_tick(plan[i].brk, plan[i].erpm, plan[i].err,
                       plan[i].fixed_due, plan[i].torque);
        end

        for (int b = 0; b < NumBlocks; b++) begin
            wait_drained();
            gap_pct   = 0;
            stall_pct = 0;
            write_reg(REG_ACCEL_CURRENT, pick_reg(4095, 4095));
            write_reg(REG_ACCEL_ANGLE,   pick_reg(7680, 3000));
            write_reg(REG_ACCEL_RAMP,    pick_reg(7680, 2000));
            write_reg(REG_BRAKE_CURRENT, pick_reg(4095, 4095));
            write_reg(REG_BRAKE_ANGLE,   pick_reg(7680, 3000));
            write_reg(REG_BRAKE_RAMP,    pick_reg(7680, 2000));
            write_reg(REG_TORQUE_SCALE,  pick_reg(65535, 65535));
            write_reg(REG_ALPHA,         pick_reg(65535, 65535));
            if ($urandom_range(3) == 0) begin
                spare = CfgIdxW'($urandom_range(REG_ALPHA + 1, (1 << CfgIdxW) - 1));
                write_reg(spare, CfgDataW'($urandom));
            end
            gap_pct   = GapPct[b % 4];
            stall_pct = StallPct[b % 4];
            // long receiver hold-off so the output register fills and input stalls
            if (b == 4 || b == 12)
                ready_hold = HoldCycles;
            for (int n = 0; n < ItemsPerBlock; n++) begin
                brk = 1'($urandom_range(1));
                case ($urandom_range(4))
                    0: erpm = ErpmW'($urandom_range(0, ErpmMin));
                    1: erpm = ErpmW'($urandom_range(ErpmMin + 1, ErpmMin + ErpmSpan));
                    2: erpm = ErpmW'($urandom_range(12990, 13010));
                    3: erpm = ErpmW'($urandom);
                    default: erpm = ErpmW'($urandom_range(0, 20000));
                endcase
                case ($urandom_range(7))
                    0: err = ErrW'($urandom);
                    1, 2: begin
                        // around the start angle and across the ramp
                        base = brk ? int'(regs.brk_ang) : int'(regs.acc_ang);
                        span = brk ? int'(regs.brk_ramp) : int'(regs.acc_ramp);
                        m = base + int'($urandom_range(0, span + 2)) - 1;
                        if (m > 32767)
                            m = 32767;
                        if ($urandom_range(1))
                            m = -m;
                        err = ErrW'(m);
                    end
                    default: err = ErrW'(int'($urandom_range(0, 46080)) - 23040);
                endcase
                offer_tick(brk, erpm, err, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TailCycles) @(posedge aclk);
        if (mismatches == 0 && pending_torque.size() == 0) begin
            $display("booster_torque_shaper_test OK");
        end else begin
            $display("booster_torque_shaper_test NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
src/bts_pkg.sv
src/bts_mul.sv
src/bts_div.sv
src/booster_torque_shaper.sv
test/booster_torque_shaper_test.sv
